### hw/rtl/ttw_pkg.sv
`timescale 1ns / 1ps

package ttw_pkg;

    localparam int SCREEN_COLS_DEF = 80;
    localparam int SCREEN_ROWS_DEF = 25;
    localparam int CELL_W          = 16;

    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_RETURN  = 8'd13;
    localparam logic [7:0] CODE_BLANK   = 8'h20;
    localparam logic [7:0] ATTR_RESET   = 8'h07;

    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUT,
        ST_RDATA,
        ST_COPY,
        ST_DRAIN,
        ST_FILL
    } t_state;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_req;

    typedef struct packed {
        logic        valid;
        logic [15:0] cell_value;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
    } t_result;

endpackage

### hw/rtl/ttw_ram.sv
`timescale 1ns / 1ps

module ttw_ram #(
    parameter int WIDTH = ttw_pkg::CELL_W,
    parameter int DEPTH = ttw_pkg::SCREEN_COLS_DEF * ttw_pkg::SCREEN_ROWS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/ttw_seq.sv
`timescale 1ns / 1ps

module ttw_seq #(
    parameter int SCREEN_COLS = ttw_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = ttw_pkg::SCREEN_ROWS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_acc,
    input  ttw_pkg::t_req    i_req,
    input  logic             i_out_free,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    output logic             o_ready,
    output ttw_pkg::t_result o_res
);
    import ttw_pkg::*;

    localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(SCREEN_COLS);
    localparam int RW    = $clog2(SCREEN_ROWS);

    localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
    localparam logic [AW-1:0] COLS_A    = AW'(SCREEN_COLS);
    localparam logic [CW-1:0] LAST_COL  = CW'(SCREEN_COLS - 1);
    localparam logic [RW-1:0] LAST_ROW  = RW'(SCREEN_ROWS - 1);
    localparam logic [31:0]   CELLS_W   = 32'(CELLS);

    t_state        r_state, n_state;
    logic [7:0]    r_attr;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [7:0]    r_code, n_code;
    logic          r_oob, n_oob;
    logic          r_cp_valid;
    logic [AW-1:0] r_cp_waddr, n_cp_waddr;

    logic [AW-1:0]     delta;
    logic [AW-1:0]     addr_sum;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;
    logic              row_step;

    ttw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The cursor address adder takes an addend that depends on the step.
    always_comb begin
        delta = '0;
        case (r_state)
            ST_PUT: begin
                if (r_code == CODE_NEWLINE) begin
                    delta = COLS_A;
                end else if (r_code == CODE_RETURN) begin
                    delta = {AW{1'b0}} - AW'(r_col);
                end else begin
                    delta = AW'(1);
                end
            end
            ST_FILL: begin
                delta = {AW{1'b0}} - COLS_A;
            end
            default: begin
                delta = '0;
            end
        endcase
    end

    assign addr_sum = r_addr + delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_attr     <= ATTR_RESET;
            r_row      <= '0;
            r_col      <= '0;
            r_addr     <= '0;
            r_wr       <= '0;
            r_cp_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_row      <= n_row;
            r_col      <= n_col;
            r_addr     <= n_addr;
            r_wr       <= n_wr;
            r_cp_valid <= (r_state == ST_COPY);
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd       <= n_rd;
        r_code     <= n_code;
        r_oob      <= n_oob;
        r_cp_waddr <= n_cp_waddr;
    end

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_col      = r_col;
        n_addr     = r_addr;
        n_wr       = r_wr;
        n_rd       = r_rd;
        n_code     = r_code;
        n_oob      = r_oob;
        n_cp_waddr = r_cp_waddr;
        ram_we     = 1'b0;
        ram_waddr  = r_wr;
        ram_wdata  = '0;
        ram_raddr  = r_rd;
        row_step   = 1'b0;
        o_ready    = (r_state == ST_IDLE) && i_out_free;
        o_res      = '0;

        // A cell read during the copy is written in the next cycle at its row above.
        if (r_cp_valid) begin
            ram_we    = 1'b1;
            ram_waddr = r_cp_waddr;
            ram_wdata = ram_rdata;
        end

        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_wr;
                ram_wdata = '0;
                n_wr      = r_wr + AW'(1);
                if (r_wr == LAST_ADDR) begin
                    n_wr    = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                ram_raddr = AW'(i_req.cell_index);
                if (i_acc) begin
                    n_code = i_req.char_code;
                    n_oob  = ({21'd0, i_req.cell_index} >= CELLS_W);
                    if (i_req.req_type == REQ_READ) begin
                        n_state = ST_RDATA;
                    end else begin
                        n_state = ST_PUT;
                    end
                end
            end
            ST_RDATA: begin
                o_res.valid      = 1'b1;
                o_res.cell_value = r_oob ? '0 : ram_rdata;
                o_res.cursor_row = 5'(r_row);
                o_res.cursor_col = 7'(r_col);
                n_state          = ST_IDLE;
            end
            ST_PUT: begin
                n_addr = addr_sum;
                if (r_code == CODE_NEWLINE) begin
                    row_step = 1'b1;
                end else if (r_code == CODE_RETURN) begin
                    n_col = '0;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_addr;
                    ram_wdata = {r_attr, r_code};
                    if (r_col == LAST_COL) begin
                        n_col    = '0;
                        row_step = 1'b1;
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
                if (row_step && (r_row == LAST_ROW)) begin
                    n_rd    = COLS_A;
                    n_wr    = '0;
                    n_state = ST_COPY;
                end else begin
                    if (row_step) begin
                        n_row = r_row + RW'(1);
                    end
                    o_res.valid      = 1'b1;
                    o_res.cursor_row = 5'(n_row);
                    o_res.cursor_col = 7'(n_col);
                    n_state          = ST_IDLE;
                end
            end
            ST_COPY: begin
                ram_raddr  = r_rd;
                n_cp_waddr = r_wr;
                n_wr       = r_wr + AW'(1);
                n_rd       = r_rd + AW'(1);
                if (r_rd == LAST_ADDR) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FILL;
            end
            ST_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_wr;
                ram_wdata = {r_attr, CODE_BLANK};
                n_wr      = r_wr + AW'(1);
                if (r_wr == LAST_ADDR) begin
                    n_wr             = '0;
                    n_addr           = addr_sum;
                    o_res.valid      = 1'b1;
                    o_res.cursor_row = 5'(r_row);
                    o_res.cursor_col = 7'(r_col);
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/text_terminal_writer_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                    Contents
// s_axis    in         s_axis_tvalid/s_axis_tready  tuser: req_type; tdata: char_code, cell_index
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: cell_value, cursor_row, cursor_col
// cfg       in         i_cfg_we                     i_cfg_wdata: text_attribute
//
// A read passes through the registered RAM read and then the output register; a put without
// scroll passes through one put step and the output register.
// In a put that scrolls, one RAM port pair first copies the cells up one cell per cycle,
// then the bottom row is filled with blanks one cell per cycle.
// After reset the screen is cleared one cell per cycle, with s_axis_tready low meanwhile.
// A new item is taken once the previous result has left or leaves in the same cycle;
// a stalled result holds in the output register.

module text_terminal_writer_top #(
    parameter int SCREEN_COLS = ttw_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = ttw_pkg::SCREEN_ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] char_code, [18:8] cell_index, rest zero
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] cell_value, [20:16] cursor_row,
                                        // [27:21] cursor_col, rest zero
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);
    import ttw_pkg::*;

    t_req    req;
    t_result res;
    t_result r_out;
    logic    r_out_valid;
    logic    out_free;
    logic    seq_ready;
    logic    acc;

    assign req.req_type   = s_axis_tuser;
    assign req.char_code  = s_axis_tdata[7:0];
    assign req.cell_index = s_axis_tdata[18:8];

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = seq_ready;
    assign acc           = s_axis_tvalid && seq_ready;

    ttw_seq #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_req       (req),
        .i_out_free  (out_free),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ready     (seq_ready),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out.cursor_col, r_out.cursor_row, r_out.cell_value};

endmodule

### hw/rtl/ttw_chk.sv
`timescale 1ns / 1ps

module ttw_chk #(
    parameter int SCREEN_ROWS = ttw_pkg::SCREEN_ROWS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // A stalled result keeps its valid and its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // An item is only taken when the output register has room for its result.
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
        else $error("item accepted with no room for its result");

    // The reported cursor row never passes the bottom of the screen.
    a_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> 32'(m_axis_tdata[20:16]) < SCREEN_ROWS)
        else $error("cursor row beyond the bottom");

    // After reset the screen is being cleared: nothing is taken or shown.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("channel active right after reset");

endmodule

bind text_terminal_writer_top ttw_chk #(.SCREEN_ROWS(SCREEN_ROWS)) u_ttw_chk (.*);
